### rtl/wcm_pkg.sv
`timescale 1ns / 1ps
package wcm_pkg;

  localparam int DEF_MAX_COMPONENTS = 8;
  localparam int DEF_MAX_SERIES     = 256;
  localparam int DEF_SAMPLE_BITS    = 16;

  localparam int WIN_W      = 4;
  localparam int SER_W      = 9;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int ROW_W      = 3;
  localparam int VAL_W      = 17;
  localparam int OUT_DATA_W = 24;
  localparam int QUO_W      = 33;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SERIES = 1'b1;

  localparam logic [VAL_W-1:0] ONE_Q16 = 17'h10000;

  typedef enum logic [1:0] {
    VAL_ONE,
    VAL_ZERO,
    VAL_RATIO
  } val_sel_e;

  typedef struct packed {
    logic     wr_en;
    logic     mac_en;
    logic     acc_clr;
    logic     norm_wr;
    logic     norm_rd;
    logic     p_ld;
    logic     q_ld;
    logic     ratio_start;
    logic     out_ld;
    logic     out_err;
    logic     out_last;
    val_sel_e val_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic p_zero;
    logic q_zero;
    logic ratio_done;
  } dp_sts_t;

endpackage

### rtl/wcm_ratio.sv
`timescale 1ns / 1ps
module wcm_ratio #(
  parameter int NW = 42
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [NW-1:0]              mag_i,
  input  logic [NW-1:0]              p_i,
  input  logic [NW-1:0]              q_i,
  output logic                       done_o,
  output logic [wcm_pkg::VAL_W-1:0]  value_o
);
  import wcm_pkg::*;

  localparam int PW   = 2 * NW;
  localparam int CNTW = $clog2(NW + QUO_W);
  localparam int BW   = $clog2(VAL_W);

  localparam logic [2:0] R_IDLE = 3'd0;
  localparam logic [2:0] R_MSQ  = 3'd1;
  localparam logic [2:0] R_MPQ  = 3'd2;
  localparam logic [2:0] R_DIV  = 3'd3;
  localparam logic [2:0] R_SQRT = 3'd4;

  logic [2:0]         phase_q, phase_d;
  logic [CNTW-1:0]    cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [PW-1:0]      mc_q, mc_d;
  logic [NW-1:0]      mp_q, mp_d;
  logic [PW-1:0]      prod_q, prod_d;
  logic [PW-1:0]      sq_q, sq_d;
  logic [PW:0]        rem_q, rem_d;
  logic [QUO_W-1:0]   quo_q, quo_d;
  logic [VAL_W-1:0]   root_q, root_d;

  logic [PW-1:0]      prod_nx;
  logic [PW:0]        rr;
  logic               ge;
  logic [VAL_W-1:0]   cand;
  logic [2*VAL_W-1:0] cand_sq;
  logic [BW-1:0]      bitpos;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    mc_d    = mc_q;
    mp_d    = mp_q;
    prod_d  = prod_q;
    sq_d    = sq_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    root_d  = root_q;
    prod_nx = mp_q[0] ? prod_q + mc_q : prod_q;
    rr      = (cnt_q == '0) ? rem_q : (rem_q << 1);
    ge      = (rr >= {1'b0, prod_q});
    bitpos  = BW'(VAL_W - 1) - BW'(cnt_q);
    cand    = root_q | (VAL_W'(1) << bitpos);
    cand_sq = cand * cand;
    case (phase_q)
      R_IDLE: begin
        if (start_i) begin
          mc_d    = PW'(mag_i);
          mp_d    = mag_i;
          prod_d  = '0;
          cnt_d   = '0;
          phase_d = R_MSQ;
        end
      end
      R_MSQ, R_MPQ: begin
        prod_d = prod_nx;
        mc_d   = mc_q << 1;
        mp_d   = mp_q >> 1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CNTW'(NW - 1)) begin
          cnt_d = '0;
          if (phase_q == R_MSQ) begin
            sq_d    = prod_nx;
            mc_d    = PW'(p_i);
            mp_d    = q_i;
            prod_d  = '0;
            phase_d = R_MPQ;
          end else begin
            rem_d   = {1'b0, sq_q};
            quo_d   = '0;
            phase_d = R_DIV;
          end
        end
      end
      R_DIV: begin
        rem_d = ge ? rr - {1'b0, prod_q} : rr;
        quo_d = {quo_q[QUO_W-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNTW'(QUO_W - 1)) begin
          cnt_d   = '0;
          root_d  = '0;
          phase_d = R_SQRT;
        end
      end
      R_SQRT: begin
        if (cand_sq <= (2*VAL_W)'(quo_q)) root_d = cand;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNTW'(VAL_W - 1)) begin
          cnt_d   = '0;
          done_d  = 1'b1;
          phase_d = R_IDLE;
        end
      end
      default: phase_d = R_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= R_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mc_q   <= mc_d;
    mp_q   <= mp_d;
    prod_q <= prod_d;
    sq_q   <= sq_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    root_q <= root_d;
  end

  assign done_o  = done_q;
  assign value_o = root_q;

endmodule

### rtl/wcm_dp.sv
`timescale 1ns / 1ps
module wcm_dp #(
  parameter int MAX_COMPONENTS = wcm_pkg::DEF_MAX_COMPONENTS,
  parameter int MAX_SERIES     = wcm_pkg::DEF_MAX_SERIES,
  parameter int SAMPLE_BITS    = wcm_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  wcm_pkg::ctrl_cmd_t                      cmd_i,
  output wcm_pkg::dp_sts_t                        sts_o,
  input  logic [$clog2(MAX_COMPONENTS+1)-1:0]     l_i,
  input  logic [$clog2(MAX_SERIES+1)-1:0]         n_i,
  input  logic signed [SAMPLE_BITS-1:0]           sample_i,
  input  logic [$clog2(MAX_COMPONENTS)-1:0]       comp_i,
  input  logic [$clog2(MAX_SERIES)-1:0]           t_i,
  input  logic [$clog2(MAX_COMPONENTS)-1:0]       i_i,
  input  logic [$clog2(MAX_COMPONENTS)-1:0]       j_i,
  input  logic [$clog2(MAX_SERIES)-1:0]           k_i,
  input  logic [$clog2(MAX_COMPONENTS)-1:0]       norm_idx_i,
  output logic [wcm_pkg::ROW_W-1:0]               row_o,
  output logic [wcm_pkg::ROW_W-1:0]               col_o,
  output logic [wcm_pkg::VAL_W-1:0]               value_o,
  output logic                                    err_o,
  output logic                                    last_o
);
  import wcm_pkg::*;

  localparam int LW    = $clog2(MAX_COMPONENTS + 1);
  localparam int NBW   = $clog2(MAX_SERIES + 1);
  localparam int XW    = ((LW > NBW) ? LW : NBW) + 1;
  localparam int DEPTH = MAX_COMPONENTS * MAX_SERIES;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = 2 * SAMPLE_BITS - 2 + $clog2(MAX_COMPONENTS * MAX_SERIES) + 1;
  localparam int ACCW  = NW + 1;
  localparam int PRW   = 2 * SAMPLE_BITS;
  localparam int TRW   = PRW + LW + 1;

  logic signed [SAMPLE_BITS-1:0] smem [DEPTH];
  logic [NW-1:0]                 nmem [MAX_COMPONENTS];

  logic [AW-1:0]                 wr_addr, rd_addr_a, rd_addr_b;
  logic signed [SAMPLE_BITS-1:0] a_q, b_q;
  logic                          v1_q, v2_q;
  logic [LW-1:0]                 w1_q, w2_q;
  logic signed [PRW-1:0]         prod_q;
  logic signed [ACCW-1:0]        acc_q;
  logic signed [TRW-1:0]         term;
  logic [NW-1:0]                 nrd_q, p_q, q_q;
  logic [NW-1:0]                 mag;
  logic [XW-1:0]                 kx, lx, nx, wsel;
  logic [LW-1:0]                 weight;
  logic                          ratio_done;
  logic [VAL_W-1:0]              ratio_val;

  assign wr_addr   = AW'(comp_i) * AW'(MAX_SERIES) + AW'(t_i);
  assign rd_addr_a = AW'(i_i) * AW'(MAX_SERIES) + AW'(k_i);
  assign rd_addr_b = AW'(j_i) * AW'(MAX_SERIES) + AW'(k_i);

  always_comb begin
    kx   = XW'(k_i);
    lx   = XW'(l_i);
    nx   = XW'(n_i);
    wsel = kx + 1'b1;
    if (lx < wsel) wsel = lx;
    if (nx - lx + 1'b1 < wsel) wsel = nx - lx + 1'b1;
    if (nx - kx < wsel) wsel = nx - kx;
    weight = LW'(wsel);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) smem[wr_addr] <= sample_i;
    if (cmd_i.mac_en) begin
      a_q <= smem[rd_addr_a];
      b_q <= smem[rd_addr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.mac_en;
      v2_q <= v1_q;
    end
  end

  assign term = prod_q * $signed({1'b0, w2_q});

  always_ff @(posedge clk_i) begin
    w1_q   <= weight;
    w2_q   <= w1_q;
    prod_q <= a_q * b_q;
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + ACCW'(term);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.norm_wr) nmem[i_i] <= acc_q[NW-1:0];
    if (cmd_i.norm_rd) nrd_q <= nmem[norm_idx_i];
    if (cmd_i.p_ld) p_q <= nrd_q;
    if (cmd_i.q_ld) q_q <= nrd_q;
  end

  assign mag = acc_q[ACCW-1] ? NW'(-acc_q) : acc_q[NW-1:0];

  wcm_ratio #(
    .NW(NW)
  ) u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.ratio_start),
    .mag_i   (mag),
    .p_i     (p_q),
    .q_i     (q_q),
    .done_o  (ratio_done),
    .value_o (ratio_val)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      row_o  <= ROW_W'(i_i);
      col_o  <= ROW_W'(j_i);
      err_o  <= cmd_i.out_err;
      last_o <= cmd_i.out_last;
      case (cmd_i.val_sel)
        VAL_ONE:   value_o <= ONE_Q16;
        VAL_RATIO: value_o <= ratio_val;
        default:   value_o <= '0;
      endcase
    end
  end

  assign sts_o.p_zero     = (p_q == '0);
  assign sts_o.q_zero     = (q_q == '0);
  assign sts_o.ratio_done = ratio_done;

endmodule

### rtl/wcm_ctrl.sv
`timescale 1ns / 1ps
module wcm_ctrl #(
  parameter int MAX_COMPONENTS = wcm_pkg::DEF_MAX_COMPONENTS,
  parameter int MAX_SERIES     = wcm_pkg::DEF_MAX_SERIES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_clr_i,
  input  logic [$clog2(MAX_COMPONENTS+1)-1:0] l_i,
  input  logic [$clog2(MAX_SERIES+1)-1:0]     n_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  input  wcm_pkg::dp_sts_t                    sts_i,
  output wcm_pkg::ctrl_cmd_t                  cmd_o,
  output logic [$clog2(MAX_COMPONENTS)-1:0]   comp_o,
  output logic [$clog2(MAX_SERIES)-1:0]       t_o,
  output logic [$clog2(MAX_COMPONENTS)-1:0]   i_o,
  output logic [$clog2(MAX_COMPONENTS)-1:0]   j_o,
  output logic [$clog2(MAX_SERIES)-1:0]       k_o,
  output logic [$clog2(MAX_COMPONENTS)-1:0]   norm_idx_o
);
  import wcm_pkg::*;

  localparam int CW  = $clog2(MAX_COMPONENTS);
  localparam int TW  = $clog2(MAX_SERIES);
  localparam int LW  = $clog2(MAX_COMPONENTS + 1);
  localparam int NBW = $clog2(MAX_SERIES + 1);
  localparam int XW  = ((LW > NBW) ? LW : NBW) + 1;

  localparam logic [3:0] ST_LOAD   = 4'd0;
  localparam logic [3:0] ST_ERR    = 4'd1;
  localparam logic [3:0] ST_NDOT   = 4'd2;
  localparam logic [3:0] ST_NDRAIN = 4'd3;
  localparam logic [3:0] ST_NWR    = 4'd4;
  localparam logic [3:0] ST_ENTRY  = 4'd5;
  localparam logic [3:0] ST_RDP    = 4'd6;
  localparam logic [3:0] ST_RDQ    = 4'd7;
  localparam logic [3:0] ST_QLD    = 4'd8;
  localparam logic [3:0] ST_CHK    = 4'd9;
  localparam logic [3:0] ST_DOT    = 4'd10;
  localparam logic [3:0] ST_DRAIN  = 4'd11;
  localparam logic [3:0] ST_RSTART = 4'd12;
  localparam logic [3:0] ST_RWAIT  = 4'd13;
  localparam logic [3:0] ST_EMIT   = 4'd14;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] comp_q, comp_d, i_q, i_d, j_q, j_d;
  logic [TW-1:0] t_q, t_d, k_q, k_d;
  logic          drain_q, drain_d;
  logic          out_valid_q, out_valid_d;
  val_sel_e      sel_q, sel_d;

  logic [XW-1:0] l_x, n_x;
  logic          last_t, last_comp, last_k, last_i, last_j, out_free;

  assign l_x       = XW'(l_i);
  assign n_x       = XW'(n_i);
  assign last_t    = (XW'(t_q) == n_x - 1'b1);
  assign last_comp = (XW'(comp_q) == l_x - 1'b1);
  assign last_k    = (XW'(k_q) == n_x - 1'b1);
  assign last_i    = (XW'(i_q) == l_x - 1'b1);
  assign last_j    = (XW'(j_q) == l_x - 1'b1);
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    comp_d  = comp_q;
    t_d     = t_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    drain_d = drain_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.val_sel = sel_q;
    case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          cmd_o.wr_en = 1'b1;
          if (last_t) begin
            t_d = '0;
            if (last_comp) begin
              comp_d  = '0;
              i_d     = '0;
              j_d     = '0;
              k_d     = '0;
              state_d = (n_x < l_x) ? ST_ERR : ST_NDOT;
            end else begin
              comp_d = comp_q + 1'b1;
            end
          end else begin
            t_d = t_q + 1'b1;
          end
        end
        if (cfg_clr_i) begin
          comp_d = '0;
          t_d    = '0;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_err  = 1'b1;
          cmd_o.out_last = 1'b1;
          cmd_o.val_sel  = VAL_ZERO;
          state_d        = ST_LOAD;
        end
      end
      ST_NDOT, ST_DOT: begin
        cmd_o.mac_en  = 1'b1;
        cmd_o.acc_clr = (k_q == '0);
        if (last_k) begin
          k_d     = '0;
          drain_d = 1'b0;
          state_d = (state_q == ST_NDOT) ? ST_NDRAIN : ST_DRAIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_NDRAIN, ST_DRAIN: begin
        drain_d = 1'b1;
        if (drain_q) state_d = (state_q == ST_NDRAIN) ? ST_NWR : ST_RSTART;
      end
      ST_NWR: begin
        cmd_o.norm_wr = 1'b1;
        if (last_i) begin
          i_d     = '0;
          j_d     = '0;
          state_d = ST_ENTRY;
        end else begin
          i_d     = i_q + 1'b1;
          j_d     = i_q + 1'b1;
          state_d = ST_NDOT;
        end
      end
      ST_ENTRY: begin
        if (i_q == j_q) begin
          sel_d   = VAL_ONE;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_RDP;
        end
      end
      ST_RDP: begin
        cmd_o.norm_rd = 1'b1;
        state_d       = ST_RDQ;
      end
      ST_RDQ: begin
        cmd_o.p_ld    = 1'b1;
        cmd_o.norm_rd = 1'b1;
        state_d       = ST_QLD;
      end
      ST_QLD: begin
        cmd_o.q_ld = 1'b1;
        state_d    = ST_CHK;
      end
      ST_CHK: begin
        if (sts_i.p_zero || sts_i.q_zero) begin
          sel_d   = VAL_ZERO;
          state_d = ST_EMIT;
        end else begin
          k_d     = '0;
          state_d = ST_DOT;
        end
      end
      ST_RSTART: begin
        cmd_o.ratio_start = 1'b1;
        state_d           = ST_RWAIT;
      end
      ST_RWAIT: begin
        if (sts_i.ratio_done) begin
          sel_d   = VAL_RATIO;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_last = last_i && last_j;
          if (last_j) begin
            j_d = '0;
            if (last_i) begin
              i_d     = '0;
              state_d = ST_LOAD;
            end else begin
              i_d     = i_q + 1'b1;
              state_d = ST_ENTRY;
            end
          end else begin
            j_d     = j_q + 1'b1;
            state_d = ST_ENTRY;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_ld) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      comp_q      <= '0;
      t_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      drain_q     <= 1'b0;
      out_valid_q <= 1'b0;
      sel_q       <= VAL_ZERO;
    end else begin
      state_q     <= state_d;
      comp_q      <= comp_d;
      t_q         <= t_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
    end
  end

  assign in_ready_o  = (state_q == ST_LOAD);
  assign out_valid_o = out_valid_q;
  assign comp_o      = comp_q;
  assign t_o         = t_q;
  assign i_o         = i_q;
  assign j_o         = j_q;
  assign k_o         = k_q;
  assign norm_idx_o  = (state_q == ST_RDQ) ? j_q : i_q;

endmodule

### rtl/w_correlation_matrix.sv
`timescale 1ns / 1ps
// channel   direction  ports                 contents
// s_axis    in         tvalid tready tdata   tdata: sample
// m_axis    out        tvalid tready tdata   tdata: row, col, value; tuser: error; tlast: last
// cfg       in         cfg_we_i cfg_idx_i    0: window_length, 1: series_length
//
// Load: one sample per cycle, L*n transfers per run.
// Off-diagonal entry: a single MAC pass over the sample memory, then the bit-serial
// multiply, divide and square root of the ratio unit. A zero-norm entry skips both.
// Reset is asynchronous; the sample and norm memories are not cleared.
// A full output register stalls the sequencer only at the point of emitting.
module w_correlation_matrix #(
  parameter int MAX_COMPONENTS = wcm_pkg::DEF_MAX_COMPONENTS,
  parameter int MAX_SERIES     = wcm_pkg::DEF_MAX_SERIES,
  parameter int SAMPLE_BITS    = wcm_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wcm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [wcm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,   // sample
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [wcm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,   // row, col, value
  output logic                                m_axis_tuser,   // error
  output logic                                m_axis_tlast
);
  import wcm_pkg::*;

  localparam int CW  = $clog2(MAX_COMPONENTS);
  localparam int TW  = $clog2(MAX_SERIES);
  localparam int LW  = $clog2(MAX_COMPONENTS + 1);
  localparam int NBW = $clog2(MAX_SERIES + 1);
  localparam int LXW = ((WIN_W > LW) ? WIN_W : LW) + 1;
  localparam int NXW = ((SER_W > NBW) ? SER_W : NBW) + 1;

  logic [WIN_W-1:0] window_q;
  logic [SER_W-1:0] series_q;
  logic [LW-1:0]    l_eff;
  logic [NBW-1:0]   n_eff;

  ctrl_cmd_t        cmd;
  dp_sts_t          sts;
  logic [CW-1:0]    comp, i_idx, j_idx, norm_idx;
  logic [TW-1:0]    t_idx, k_idx;
  logic [ROW_W-1:0] row, col;
  logic [VAL_W-1:0] value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WIN_W'(2);
      series_q <= SER_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WINDOW: window_q <= cfg_data_i[WIN_W-1:0];
        REG_SERIES: series_q <= cfg_data_i[SER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (LXW'(window_q) < LXW'(2)) l_eff = LW'(2);
    else if (LXW'(window_q) > LXW'(MAX_COMPONENTS)) l_eff = LW'(MAX_COMPONENTS);
    else l_eff = LW'(window_q);
    if (series_q == '0) n_eff = NBW'(1);
    else if (NXW'(series_q) > NXW'(MAX_SERIES)) n_eff = NBW'(MAX_SERIES);
    else n_eff = NBW'(series_q);
  end

  wcm_ctrl #(
    .MAX_COMPONENTS(MAX_COMPONENTS),
    .MAX_SERIES    (MAX_SERIES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_clr_i  (cfg_we_i),
    .l_i        (l_eff),
    .n_i        (n_eff),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .comp_o     (comp),
    .t_o        (t_idx),
    .i_o        (i_idx),
    .j_o        (j_idx),
    .k_o        (k_idx),
    .norm_idx_o (norm_idx)
  );

  wcm_dp #(
    .MAX_COMPONENTS(MAX_COMPONENTS),
    .MAX_SERIES    (MAX_SERIES),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .l_i       (l_eff),
    .n_i       (n_eff),
    .sample_i  ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
    .comp_i    (comp),
    .t_i       (t_idx),
    .i_i       (i_idx),
    .j_i       (j_idx),
    .k_i       (k_idx),
    .norm_idx_i(norm_idx),
    .row_o     (row),
    .col_o     (col),
    .value_o   (value),
    .err_o     (m_axis_tuser),
    .last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - 2*ROW_W - VAL_W){1'b0}}, value, col, row};

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("error transfer without last");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("error transfer with nonzero data");

  a_diag_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser && row == col |-> value == ONE_Q16)
    else $error("diagonal entry not one");

  a_val_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> value <= ONE_Q16)
    else $error("value above one");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import wcm_pkg::*;

  localparam int NCOMP     = DEF_MAX_COMPONENTS;
  localparam int NSER      = DEF_MAX_SERIES;
  localparam int CYC_LIMIT = 2000000;
  localparam int SETTLE    = 200;

  typedef enum logic [1:0] {CHK_MODEL, CHK_ERROR, CHK_IDENT2} chk_e;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             error;
    logic             last;
  } entry_t;

  typedef struct {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic signed [15:0]    sample;
    chk_e                  chk;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // sample
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;  // row, col, value
  logic m_axis_tuser;  // error
  logic m_axis_tlast;

  w_correlation_matrix u_dut (.*);

  always #5 clk_i = ~clk_i;

  logic signed [15:0] series_mem [NCOMP][NSER];
  logic [3:0] win_reg;
  logic [8:0] ser_reg;
  int unsigned load_cnt;
  entry_t corr_q[$];
  entry_t fresh_q[$];
  int fail_cnt, entry_cnt, run_cnt, sample_cnt;
  longint unsigned cyc = 0;
  bit calm;

  function automatic int eff_win();
    return win_reg < 2 ? 2 : (win_reg > NCOMP ? NCOMP : win_reg);
  endfunction

  function automatic int eff_ser();
    return ser_reg < 1 ? 1 : (ser_reg > NSER ? NSER : ser_reg);
  endfunction

  function automatic longint hankel_w(int k, int l, int n);
    int w;
    w = k + 1;
    if (l < w) w = l;
    if (n - l + 1 < w) w = n - l + 1;
    if (n - k < w) w = n - k;
    return w;
  endfunction

  function automatic logic [VAL_W-1:0] q16_corr(longint inner, longint unsigned p,
                                                 longint unsigned q);
    logic [127:0] mag, rhs, pq, lhs;
    int unsigned lo, hi, mid;
    mag = inner < 0 ? 128'(-inner) : 128'(inner);
    rhs = (mag * mag) << 32;
    pq = 128'(p) * 128'(q);
    lo = 0;
    hi = 65536;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      lhs = 128'(mid) * 128'(mid) * pq;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo[VAL_W-1:0];
  endfunction

  task automatic correlate_sample(input logic signed [15:0] s);
    int l, n, comp;
    longint unsigned norms [NCOMP];
    longint acc, inner;
    entry_t e;
    l = eff_win();
    n = eff_ser();
    comp = load_cnt / n;
    if (comp < NCOMP) series_mem[comp][load_cnt % n] = s;
    load_cnt++;
    if (load_cnt < l * n) return;
    load_cnt = 0;
    run_cnt++;
    if (n < l) begin
      fresh_q.push_back('{row: 0, col: 0, value: 0, error: 1'b1, last: 1'b1});
      return;
    end
    for (int i = 0; i < l; i++) begin
      acc = 0;
      for (int k = 0; k < n; k++)
        acc += hankel_w(k, l, n) * longint'(series_mem[i][k]) * longint'(series_mem[i][k]);
      norms[i] = acc;
    end
    for (int i = 0; i < l; i++)
      for (int j = 0; j < l; j++) begin
        e.row = ROW_W'(i);
        e.col = ROW_W'(j);
        e.error = 1'b0;
        e.last = (i == l - 1) && (j == l - 1);
        if (i == j) e.value = ONE_Q16;
        else if (norms[i] == 0 || norms[j] == 0) e.value = '0;
        else begin
          inner = 0;
          for (int k = 0; k < n; k++)
            inner += hankel_w(k, l, n) * longint'(series_mem[i][k])
                   * longint'(series_mem[j][k]);
          e.value = q16_corr(inner, norms[i], norms[j]);
        end
        fresh_q.push_back(e);
      end
  endtask

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_WINDOW) win_reg = data[3:0];
    else ser_reg = data;
    load_cnt = 0;
    @(negedge clk_i);
  endtask

  task automatic send_sample(input logic signed [15:0] s, input chk_e chk);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= s;
    do @(posedge clk_i); while (!s_axis_tready);
    sample_cnt++;
    correlate_sample(s);
    if (chk == CHK_ERROR)
      fresh_q = '{'{row: 0, col: 0, value: 0, error: 1'b1, last: 1'b1}};
    else if (chk == CHK_IDENT2)
      fresh_q = '{'{0, 0, ONE_Q16, 1'b0, 1'b0}, '{0, 1, 17'd0, 1'b0, 1'b0},
                  '{1, 0, 17'd0, 1'b0, 1'b0}, '{1, 1, ONE_Q16, 1'b0, 1'b1}};
    while (fresh_q.size() > 0) corr_q.push_back(fresh_q.pop_front());
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (corr_q.size() > 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic random_run(input logic [3:0] w, input logic [8:0] n);
    int l, ns, mode;
    logic signed [15:0] s;
    write_reg(REG_WINDOW, 9'(w));
    write_reg(REG_SERIES, n);
    l = eff_win();
    ns = eff_ser();
    calm = ($urandom_range(0, 3) == 0);
    for (int c = 0; c < l; c++) begin
      mode = $urandom_range(0, 5);
      for (int k = 0; k < ns; k++) begin
        case (mode)
          1: s = 0;
          2: s = (c > 0) ? -series_mem[0][k] : 16'($urandom);
          3: s = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          4: s = 16'($signed($urandom_range(0, 15)) - 8);
          default: s = 16'($urandom);
        endcase
        send_sample(s, CHK_MODEL);
      end
    end
    drain();
  endtask

  row_t dir_tbl[$] = '{
    '{1, REG_WINDOW, 9'd3, 0, CHK_MODEL},
    '{1, REG_SERIES, 9'd2, 0, CHK_MODEL},
    '{0, 0, 0, -16'sd32768, CHK_MODEL},
    '{0, 0, 0, 16'sd32767, CHK_MODEL},
    '{0, 0, 0, 16'sd0, CHK_MODEL},
    '{0, 0, 0, -16'sd1, CHK_MODEL},
    '{0, 0, 0, 16'sd1, CHK_MODEL},
    '{0, 0, 0, 16'sh5555, CHK_ERROR},
    '{1, REG_WINDOW, 9'd0, 0, CHK_MODEL},
    '{1, REG_SERIES, 9'd4, 0, CHK_MODEL},
    '{0, 0, 0, 16'sd0, CHK_MODEL},
    '{0, 0, 0, 16'sd0, CHK_MODEL},
    '{0, 0, 0, 16'sd0, CHK_MODEL},
    '{0, 0, 0, 16'sd0, CHK_MODEL},
    '{0, 0, 0, 16'sd32767, CHK_MODEL},
    '{0, 0, 0, -16'sd32768, CHK_MODEL},
    '{0, 0, 0, 16'sh2aaa, CHK_MODEL},
    '{0, 0, 0, -16'sd1, CHK_IDENT2},
    '{0, 0, 0, 16'sd32767, CHK_MODEL},
    '{0, 0, 0, -16'sd32768, CHK_MODEL},
    '{0, 0, 0, 16'sd1234, CHK_MODEL},
    '{0, 0, 0, -16'sd7, CHK_MODEL},
    '{0, 0, 0, 16'sd32767, CHK_MODEL},
    '{0, 0, 0, -16'sd32768, CHK_MODEL},
    '{0, 0, 0, 16'sd1234, CHK_MODEL},
    '{0, 0, 0, -16'sd7, CHK_MODEL}
  };

  always @(negedge clk_i)
    m_axis_tready <= (pick_gap() == 0);

  always @(posedge clk_i) begin
    entry_t got, want;
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[2:0], m_axis_tdata[5:3], m_axis_tdata[22:6],
              m_axis_tuser, m_axis_tlast};
      if (corr_q.size() == 0) begin
        $error("unexpected transfer row=%0d col=%0d value=%0d", got.row, got.col, got.value);
        fail_cnt++;
      end else begin
        want = corr_q.pop_front();
        entry_cnt++;
        if (got.row !== want.row) begin
          $error("row: expected %0d, got %0d", want.row, got.row); fail_cnt++;
        end
        if (got.col !== want.col) begin
          $error("col: expected %0d, got %0d", want.col, got.col); fail_cnt++;
        end
        if (got.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, got.value); fail_cnt++;
        end
        if (got.error !== want.error) begin
          $error("error: expected %0d, got %0d", want.error, got.error); fail_cnt++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last); fail_cnt++;
        end
      end
    end
  end

  initial begin
    int rand_items;
    win_reg = 4'd2;
    ser_reg = 9'd256;
    load_cnt = 0;
    calm = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].is_cfg) begin
        drain();
        write_reg(dir_tbl[i].idx, dir_tbl[i].data);
      end else send_sample(dir_tbl[i].sample, dir_tbl[i].chk);
    end
    drain();
    random_run(4'd15, 9'd3);
    random_run(4'd8, 9'd8);
    random_run(4'd2, 9'd0);
    random_run(4'd1, 9'd5);
    rand_items = 0;
    while (rand_items < 80) begin
      int w, n;
      w = $urandom_range(2, 8);
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, w) : $urandom_range(w, w + 4);
      rand_items += w * n;
      random_run(4'(w), 9'(n));
    end
    drain();
    $display("%0d samples in %0d runs, %0d matrix entries checked", sample_cnt, run_cnt,
             entry_cnt);
    $display("window 2..8 incl. saturated writes, series 0..12, short-series errors");
    if (fail_cnt == 0 && corr_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/wcm_pkg.sv
rtl/wcm_ratio.sv
rtl/wcm_dp.sv
rtl/wcm_ctrl.sv
rtl/w_correlation_matrix.sv
dv/testbench.sv
